FILE: design/wrld_pkg.sv
// ----------------------------------------------------------------------------
// wrld_pkg: shared types for the word run-length raster decoder
// Decode phases, the classified byte token passed from front to back end,
// and the result record.
// ----------------------------------------------------------------------------
package wrld_pkg;

  typedef enum logic [6:0] {
    PH_ROWS_LO = 7'b0000001,
    PH_ROWS_HI = 7'b0000010,
    PH_WID_LO  = 7'b0000100,
    PH_WID_HI  = 7'b0001000,
    PH_CONTROL = 7'b0010000,
    PH_BYTE_A  = 7'b0100000,
    PH_BYTE_B  = 7'b1000000
  } phase_t;

  // One input byte together with its reading as a control byte.
  typedef struct packed {
    logic [7:0] data;
    logic       ended;
    logic       is_repeat;
    logic [6:0] count;
    logic       lit_zero;
  } tok_t;

  typedef struct packed {
    logic [14:0] row;
    logic [15:0] column;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [6:0]  repeat_res;
    logic        error;
    logic        last;
  } res_t;

endpackage

FILE: design/wrld_front.sv
// ----------------------------------------------------------------------------
// wrld_front: input acceptance, byte classification and token queue
// Each accepted byte is classified as a control byte and stored in a
// two-entry queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
module wrld_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     data_byte,
  input  logic           stream_ended,
  output logic           q_valid,
  output wrld_pkg::tok_t q_tok,
  input  logic           q_pop
);
  import wrld_pkg::*;

  tok_t       entry [2];
  tok_t       tok_in;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    tok_in.data      = data_byte;
    tok_in.ended     = stream_ended;
    tok_in.is_repeat = data_byte[7];
    tok_in.count     = data_byte[6:0];
    tok_in.lit_zero  = (data_byte[7] == 1'b0) && (data_byte[6:0] == 7'd0);
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_tok    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/wrld_back.sv
// ----------------------------------------------------------------------------
// wrld_back: decode state machine and result register
// Consumes one token per cycle unless its result meets a full result register;
// tracks header, row and run state, and loads the register for each result.
// ----------------------------------------------------------------------------
module wrld_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  wrld_pkg::tok_t q_tok,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output wrld_pkg::res_t out_res
);
  import wrld_pkg::*;

  phase_t             phase, phase_next;
  logic [7:0]         header_low, header_low_next;
  logic [15:0]        rows_total, rows_total_next;
  logic [15:0]        row_words, row_words_next;
  logic [15:0]        row_index, row_index_next;
  logic signed [16:0] words_left, words_left_next;
  logic [15:0]        column_pos, column_pos_next;
  logic               run_is_repeat, run_is_repeat_next;
  logic [6:0]         run_count, run_count_next;
  logic [7:0]         held_byte, held_byte_next;

  logic        emit;
  res_t        res;
  logic        in_rows;
  logic [15:0] width;
  logic [6:0]  rep;
  logic        run_done;

  assign in_rows = (phase == PH_CONTROL) || (phase == PH_BYTE_A) || (phase == PH_BYTE_B);
  assign width   = {q_tok.data, header_low};

  always_comb begin
    phase_next         = phase;
    header_low_next    = header_low;
    rows_total_next    = rows_total;
    row_words_next     = row_words;
    row_index_next     = row_index;
    words_left_next    = words_left;
    column_pos_next    = column_pos;
    run_is_repeat_next = run_is_repeat;
    run_count_next     = run_count;
    held_byte_next     = held_byte;
    emit               = 1'b0;
    res                = '0;
    rep                = 7'd1;
    run_done           = 1'b0;

    if (q_tok.ended) begin
      emit        = 1'b1;
      res.row     = in_rows ? row_index[14:0] : 15'd0;
      res.column  = in_rows ? column_pos : 16'd0;
      res.error   = 1'b1;
      res.last    = 1'b1;
      phase_next  = PH_ROWS_LO;
    end else begin
      case (phase)
        PH_ROWS_LO: begin
          header_low_next = q_tok.data;
          phase_next      = PH_ROWS_HI;
        end
        PH_ROWS_HI: begin
          rows_total_next = {q_tok.data, header_low};
          phase_next      = PH_WID_LO;
        end
        PH_WID_LO: begin
          header_low_next = q_tok.data;
          phase_next      = PH_WID_HI;
        end
        PH_WID_HI: begin
          row_words_next = width;
          row_index_next = 16'd0;
          // Zero or negative dimensions mean an empty image.
          if ((rows_total == 16'd0) || rows_total[15] || (width == 16'd0) || width[15]) begin
            emit       = 1'b1;
            res.last   = 1'b1;
            phase_next = PH_ROWS_LO;
          end else begin
            words_left_next = {1'b0, width};
            column_pos_next = 16'd0;
            phase_next      = PH_CONTROL;
          end
        end
        PH_CONTROL: begin
          run_is_repeat_next = q_tok.is_repeat;
          run_count_next     = q_tok.count;
          if (q_tok.lit_zero) begin
            emit       = 1'b1;
            res.row    = row_index[14:0];
            res.column = column_pos;
            res.error  = 1'b1;
            res.last   = 1'b1;
            phase_next = PH_ROWS_LO;
          end else begin
            words_left_next = words_left - $signed({10'd0, q_tok.count});
            phase_next      = PH_BYTE_A;
          end
        end
        PH_BYTE_A: begin
          held_byte_next = q_tok.data;
          phase_next     = PH_BYTE_B;
        end
        PH_BYTE_B: begin
          if (run_is_repeat) begin
            // A repeat count of zero still writes one word.
            rep      = (run_count == 7'd0) ? 7'd1 : run_count;
            run_done = 1'b1;
          end else begin
            run_count_next = run_count - 7'd1;
            run_done       = (run_count == 7'd1);
          end
          column_pos_next = column_pos + {9'd0, rep};
          emit            = 1'b1;
          res.row         = row_index[14:0];
          res.column      = column_pos;
          res.first_byte  = held_byte;
          res.second_byte = q_tok.data;
          res.repeat_res  = rep;
          if (!run_done) begin
            phase_next = PH_BYTE_A;
          end else if (words_left <= 17'sd0) begin
            if (({1'b0, row_index} + 17'd1) >= {1'b0, rows_total}) begin
              res.last   = 1'b1;
              phase_next = PH_ROWS_LO;
            end else begin
              row_index_next  = row_index + 16'd1;
              words_left_next = {1'b0, row_words};
              column_pos_next = 16'd0;
              phase_next      = PH_CONTROL;
            end
          end else begin
            phase_next = PH_CONTROL;
          end
        end
        default: begin
          phase_next = PH_ROWS_LO;
        end
      endcase
    end
  end

  // A token that yields a result waits until the result register can take it.
  assign q_pop = q_valid && (!emit || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_ROWS_LO;
      header_low    <= 8'd0;
      rows_total    <= 16'd0;
      row_words     <= 16'd0;
      row_index     <= 16'd0;
      words_left    <= 17'sd0;
      column_pos    <= 16'd0;
      run_is_repeat <= 1'b0;
      run_count     <= 7'd0;
      held_byte     <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        phase         <= phase_next;
        header_low    <= header_low_next;
        rows_total    <= rows_total_next;
        row_words     <= row_words_next;
        row_index     <= row_index_next;
        words_left    <= words_left_next;
        column_pos    <= column_pos_next;
        run_is_repeat <= run_is_repeat_next;
        run_count     <= run_count_next;
        held_byte     <= held_byte_next;
      end
      if (q_pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_res <= res;
    end
  end

endmodule

FILE: design/word_rle_raster_decoder.sv
// ----------------------------------------------------------------------------
// word_rle_raster_decoder: run-length coded raster stream decoder
// Decodes a byte stream of 16-bit raster words into repeat and literal
// word results tagged with row and column.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle while the queue has room and gives
// at most one result per byte, so a steady stream runs at one item per cycle
// while the output accepts results. Each result is registered as its token
// leaves the queue. A two-entry byte queue separates input acceptance from
// the decode state machine, and a result register separates the state machine
// from the output, so a stalled output stops the input only after the queue
// has filled. The row count and row width header, control bytes and data bytes
// are all handled by the same combinational state update.
module word_rle_raster_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        stream_ended,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] row,
  output logic [15:0] column,
  output logic [7:0]  first_byte,
  output logic [7:0]  second_byte,
  output logic [6:0]  repeat_res,
  output logic        error,
  output logic        last
);
  import wrld_pkg::*;

  logic q_valid;
  logic q_pop;
  tok_t q_tok;
  res_t out_res;

  wrld_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .stream_ended (stream_ended),
    .q_valid      (q_valid),
    .q_tok        (q_tok),
    .q_pop        (q_pop)
  );

  wrld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_tok     (q_tok),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign row         = out_res.row;
  assign column      = out_res.column;
  assign first_byte  = out_res.first_byte;
  assign second_byte = out_res.second_byte;
  assign repeat_res  = out_res.repeat_res;
  assign error       = out_res.error;
  assign last        = out_res.last;

endmodule
